/* hdl/drr_pkg.sv */
// Package for the driver risk rule engine: field widths, alert and risk codes,
// register indexes and configuration reset values. No dependencies.
package drr_pkg;

	localparam int IN_TDATA_W  = 88;
	localparam int OUT_TDATA_W = 64;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 32;
	localparam int EVT_OUT_W   = 16;

	typedef enum logic [1:0] {
		RISK_CLEAR    = 2'd0,
		RISK_NOTICE   = 2'd1,
		RISK_WARNING  = 2'd2,
		RISK_CRITICAL = 2'd3
	} risk_t;

	typedef enum logic [2:0] {
		ALERT_NONE   = 3'd0,
		ALERT_DROWSY = 3'd1,
		ALERT_PHONE  = 3'd2,
		ALERT_CRASH  = 3'd3,
		ALERT_SENSOR = 3'd4
	} alert_t;

	typedef enum logic [2:0] {
		REG_PERCLOS_CRITICAL = 3'd0,
		REG_PERCLOS_WARNING  = 3'd1,
		REG_PERCLOS_NOTICE   = 3'd2,
		REG_COLLISION_SQ     = 3'd3,
		REG_COLLISION_HOLD   = 3'd4,
		REG_HARSH_SQ         = 3'd5,
		REG_TURN_LIMIT       = 3'd6,
		REG_RECOVERY_PERIOD  = 3'd7
	} cfg_idx_t;

	localparam logic [15:0] RST_PERCLOS_CRITICAL = 16'd32768;
	localparam logic [15:0] RST_PERCLOS_WARNING  = 16'd19661;
	localparam logic [15:0] RST_PERCLOS_NOTICE   = 16'd9830;
	localparam logic [31:0] RST_COLLISION_SQ     = 32'd1557504;
	localparam logic [15:0] RST_COLLISION_HOLD   = 16'd200;
	localparam logic [31:0] RST_HARSH_SQ         = 32'd4096;
	localparam logic [14:0] RST_TURN_LIMIT       = 15'd1920;
	localparam logic [15:0] RST_RECOVERY_PERIOD  = 16'd1000;

	localparam logic signed [15:0] HARSH_AX = 16'sd48;
	localparam logic [6:0] SCORE_MAX    = 7'd100;
	localparam logic [6:0] BRAKE_COST   = 7'd3;
	localparam logic [6:0] ACCEL_COST   = 7'd2;
	localparam logic [6:0] TURN_COST    = 7'd2;

	// one tick request after the input register
	typedef struct packed {
		logic        imu_present;
		logic [15:0] accel_x;
		logic [15:0] accel_y;
		logic [15:0] accel_z;
		logic [15:0] yaw_rate;
		logic        camera_present;
		logic [1:0]  camera_fatigue_level;
		logic [15:0] eye_closure_ratio;
		logic        phone_in_use;
		logic        sensors_healthy;
	} tick_t;

endpackage

/* hdl/driver_risk_rule_engine.sv */
// Driver risk rule engine top level: input register, rule logic, trip score
// state and result register. Depends on drr_pkg.
//
// channel  dir  handshake           payload
// s_*      in   s_tvalid/s_tready   s_tdata: one 50 ms sensor tick
// m_*      out  m_tvalid/m_tready   m_tdata: risk, alert, score, event counts
// cfg_*    in   cfg_we              cfg_index, cfg_data: threshold registers
//
// One request per cycle sustained while the result is not stalled; a request passes the input
// register, then the result register after the squarers and compares.
// arst_n clears valids, trip state (score 100) and registers to their defaults.
// A stalled result holds in the result register; the input register still takes
// one more request, and s_tready drops only when both stages are full.
module driver_risk_rule_engine #(
	parameter int COUNT_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// imu_present, accel_x, accel_y, accel_z, yaw_rate, camera_present,
	// camera_fatigue_level, eye_closure_ratio, phone_in_use, sensors_healthy, 2'b0
	input  logic [drr_pkg::IN_TDATA_W-1:0]    s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// risk_level, alert_kind, score, brake_events, accel_events,
	// turn_events, 4'b0
	output logic [drr_pkg::OUT_TDATA_W-1:0]   m_tdata,
	input  logic                              cfg_we,
	input  logic [drr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [drr_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	// configuration
	logic [15:0] perclos_critical_q, perclos_warning_q, perclos_notice_q;
	logic [31:0] collision_sq_q, harsh_sq_q;
	logic [15:0] collision_hold_q, recovery_period_q;
	logic [14:0] turn_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			perclos_critical_q <= drr_pkg::RST_PERCLOS_CRITICAL;
			perclos_warning_q  <= drr_pkg::RST_PERCLOS_WARNING;
			perclos_notice_q   <= drr_pkg::RST_PERCLOS_NOTICE;
			collision_sq_q     <= drr_pkg::RST_COLLISION_SQ;
			collision_hold_q   <= drr_pkg::RST_COLLISION_HOLD;
			harsh_sq_q         <= drr_pkg::RST_HARSH_SQ;
			turn_limit_q       <= drr_pkg::RST_TURN_LIMIT;
			recovery_period_q  <= drr_pkg::RST_RECOVERY_PERIOD;
		end else if (cfg_we) begin
			unique case (drr_pkg::cfg_idx_t'(cfg_index))
				drr_pkg::REG_PERCLOS_CRITICAL: perclos_critical_q <= cfg_data[15:0];
				drr_pkg::REG_PERCLOS_WARNING:  perclos_warning_q  <= cfg_data[15:0];
				drr_pkg::REG_PERCLOS_NOTICE:   perclos_notice_q   <= cfg_data[15:0];
				drr_pkg::REG_COLLISION_SQ:     collision_sq_q     <= cfg_data;
				drr_pkg::REG_COLLISION_HOLD:   collision_hold_q   <= cfg_data[15:0];
				drr_pkg::REG_HARSH_SQ:         harsh_sq_q         <= cfg_data;
				drr_pkg::REG_TURN_LIMIT:       turn_limit_q       <= cfg_data[14:0];
				drr_pkg::REG_RECOVERY_PERIOD:  recovery_period_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// input register
	logic           tick_valid_s1;
	drr_pkg::tick_t tick_s1;
	logic           advance;
	logic           m_tvalid_q;
	logic [drr_pkg::OUT_TDATA_W-1:0] m_tdata_q;

	assign advance  = tick_valid_s1 && (!m_tvalid_q || m_tready);
	assign s_tready = !tick_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			tick_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			tick_s1.imu_present          <= s_tdata[0];
			tick_s1.accel_x              <= s_tdata[16:1];
			tick_s1.accel_y              <= s_tdata[32:17];
			tick_s1.accel_z              <= s_tdata[48:33];
			tick_s1.yaw_rate             <= s_tdata[64:49];
			tick_s1.camera_present       <= s_tdata[65];
			tick_s1.camera_fatigue_level <= s_tdata[67:66];
			tick_s1.eye_closure_ratio    <= s_tdata[83:68];
			tick_s1.phone_in_use         <= s_tdata[84];
			tick_s1.sensors_healthy      <= s_tdata[85];
		end
	end

	// trip state
	logic                  impact_active_q;
	logic [15:0]           impact_ticks_q;
	logic [15:0]           recovery_phase_q;
	logic [6:0]            score_q;
	logic [COUNT_BITS-1:0] brake_q, accel_q, turn_q;

	logic                  impact_active_d;
	logic [15:0]           impact_ticks_d;
	logic [15:0]           phase_inc, recovery_phase_d;
	logic [6:0]            score_d;
	logic [COUNT_BITS-1:0] brake_d, accel_d, turn_d;
	logic                  wrap;
	logic signed [31:0]    sq_x, sq_y, sq_z;
	logic [31:0]           mag;
	logic [15:0]           gabs;
	drr_pkg::risk_t        risk;
	drr_pkg::alert_t       alert;

	always_comb begin
		sq_x = $signed(tick_s1.accel_x) * $signed(tick_s1.accel_x);
		sq_y = $signed(tick_s1.accel_y) * $signed(tick_s1.accel_y);
		sq_z = $signed(tick_s1.accel_z) * $signed(tick_s1.accel_z);
		mag  = unsigned'(sq_x) + unsigned'(sq_y) + unsigned'(sq_z);
		gabs = tick_s1.yaw_rate[15] ? 16'(-tick_s1.yaw_rate) : tick_s1.yaw_rate;

		phase_inc        = recovery_phase_q + 16'd1;
		wrap             = phase_inc >= recovery_period_q;
		recovery_phase_d = wrap ? 16'd0 : phase_inc;

		risk            = drr_pkg::RISK_CLEAR;
		alert           = drr_pkg::ALERT_NONE;
		impact_active_d = impact_active_q;
		impact_ticks_d  = impact_ticks_q;
		score_d         = score_q;
		brake_d         = brake_q;
		accel_d         = accel_q;
		turn_d          = turn_q;

		// collision hold
		if (tick_s1.imu_present) begin
			if (mag > collision_sq_q) begin
				impact_active_d = 1'b1;
				if (!impact_active_q) begin
					impact_ticks_d = 16'd1;
				end else if (impact_ticks_q != 16'hFFFF) begin
					impact_ticks_d = impact_ticks_q + 16'd1;
				end
				if (impact_ticks_d > collision_hold_q) begin
					risk  = drr_pkg::RISK_CRITICAL;
					alert = drr_pkg::ALERT_CRASH;
				end
			end else begin
				impact_active_d = 1'b0;
				impact_ticks_d  = 16'd0;
			end
		end

		// fatigue and distraction
		if (tick_s1.camera_present) begin
			if (tick_s1.camera_fatigue_level[1] ||
			    tick_s1.eye_closure_ratio > perclos_critical_q) begin
				risk  = drr_pkg::RISK_CRITICAL;
				alert = drr_pkg::ALERT_DROWSY;
			end else if (tick_s1.eye_closure_ratio > perclos_warning_q) begin
				risk  = drr_pkg::RISK_WARNING;
				alert = drr_pkg::ALERT_DROWSY;
			end else if (tick_s1.eye_closure_ratio > perclos_notice_q) begin
				// notice band leaves risk and alert alone
			end else if (tick_s1.phone_in_use) begin
				alert = drr_pkg::ALERT_PHONE;
			end
		end

		if (!tick_s1.sensors_healthy) begin
			risk  = drr_pkg::RISK_CRITICAL;
			alert = drr_pkg::ALERT_SENSOR;
		end

		// trip score
		if (tick_s1.imu_present) begin
			if (mag > harsh_sq_q) begin
				if ($signed(tick_s1.accel_x) < -drr_pkg::HARSH_AX) begin
					if (brake_q != CNT_MAX) brake_d = brake_q + 1'b1;
					score_d = (score_d > drr_pkg::BRAKE_COST) ?
					          score_d - drr_pkg::BRAKE_COST : 7'd0;
				end else if ($signed(tick_s1.accel_x) > drr_pkg::HARSH_AX) begin
					if (accel_q != CNT_MAX) accel_d = accel_q + 1'b1;
					score_d = (score_d > drr_pkg::ACCEL_COST) ?
					          score_d - drr_pkg::ACCEL_COST : 7'd0;
				end
			end
			if (gabs > {1'b0, turn_limit_q}) begin
				if (turn_q != CNT_MAX) turn_d = turn_q + 1'b1;
				score_d = (score_d > drr_pkg::TURN_COST) ?
				          score_d - drr_pkg::TURN_COST : 7'd0;
			end
			if (wrap && score_d < drr_pkg::SCORE_MAX) score_d = score_d + 7'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			impact_active_q  <= 1'b0;
			impact_ticks_q   <= '0;
			recovery_phase_q <= '0;
			score_q          <= drr_pkg::SCORE_MAX;
			brake_q          <= '0;
			accel_q          <= '0;
			turn_q           <= '0;
		end else if (advance) begin
			impact_active_q  <= impact_active_d;
			impact_ticks_q   <= impact_ticks_d;
			recovery_phase_q <= recovery_phase_d;
			score_q          <= score_d;
			brake_q          <= brake_d;
			accel_q          <= accel_d;
			turn_q           <= turn_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (advance) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_tdata_q <= {4'b0,
			              drr_pkg::EVT_OUT_W'(turn_d),
			              drr_pkg::EVT_OUT_W'(accel_d),
			              drr_pkg::EVT_OUT_W'(brake_d),
			              score_d, alert, risk};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_score_cap: assert property (@(posedge clk) disable iff (!arst_n)
		score_q <= drr_pkg::SCORE_MAX)
		else $error("trip score above maximum");

	a_impact_ticks: assert property (@(posedge clk) disable iff (!arst_n)
		impact_active_q == (impact_ticks_q != 16'd0))
		else $error("impact flag and tick count disagree");

	a_fault_critical: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && m_tdata_q[4:2] == drr_pkg::ALERT_SENSOR |->
		m_tdata_q[1:0] == drr_pkg::RISK_CRITICAL)
		else $error("fault alert without critical risk");

	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tick_valid_s1 && !advance |=> tick_valid_s1 && $stable(tick_s1))
		else $error("stalled tick lost from input register");

endmodule

/* sim/driver_risk_rule_engine_check.sv */
// Scoreboard for the driver risk rule engine: tracks register writes, predicts one
// report per accepted tick request and compares it with the result stream.
// Depends on drr_pkg.
module driver_risk_rule_engine_check #(
	parameter int COUNT_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [drr_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [drr_pkg::OUT_TDATA_W-1:0] m_tdata,
	input  logic                            cfg_we,
	input  logic [drr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [drr_pkg::CFG_DATA_W-1:0]  cfg_data,
	output int                              mismatch_count,
	output int                              reports_due
);

	localparam longint EVENT_MAX = (longint'(1) << COUNT_BITS) - 1;
	localparam int HARSH_AX_LIMIT = 48;
	localparam int SCORE_CAP = 100;
	localparam int BRAKE_PENALTY = 3;
	localparam int ACCEL_PENALTY = 2;
	localparam int TURN_PENALTY = 2;

	typedef struct packed {
		drr_pkg::risk_t  risk;
		drr_pkg::alert_t alert;
		logic [6:0]  score;
		logic [15:0] brakes;
		logic [15:0] accels;
		logic [15:0] turns;
	} tick_report_t;

	tick_report_t expected_reports[$];
	tick_report_t got, want;
	int errors;

	logic [15:0] perclos_crit, perclos_warn, perclos_note, hold_ticks, period;
	logic [31:0] impact_sq, harsh_sq;
	logic [14:0] turn_limit;

	logic   impact_on;
	int     impact_count, phase, score;
	longint brake_total, accel_total, turn_total;

	function automatic void deduct_points(int pts);
		score = (score > pts) ? score - pts : 0;
	endfunction

	task automatic apply_tick_rules(input logic [drr_pkg::IN_TDATA_W-1:0] d);
		logic signed [15:0] ax, ay, az, gz;
		logic [15:0] perclos;
		longint unsigned mag;
		int yaw_abs;
		logic wrap;
		tick_report_t r;
		ax = d[16:1];
		ay = d[32:17];
		az = d[48:33];
		gz = d[64:49];
		perclos = d[83:68];
		mag = longint'(ax) * longint'(ax) + longint'(ay) * longint'(ay)
			+ longint'(az) * longint'(az);
		yaw_abs = (gz < 0) ? -int'(gz) : int'(gz);
		r.risk = drr_pkg::RISK_CLEAR;
		r.alert = drr_pkg::ALERT_NONE;

		phase = (phase + 1) & 16'hFFFF;
		wrap = phase >= int'(period);
		if (wrap)
			phase = 0;

		if (d[0]) begin
			if (mag > impact_sq) begin
				if (!impact_on) begin
					impact_on = 1'b1;
					impact_count = 0;
				end
				if (impact_count < 16'hFFFF)
					impact_count++;
				if (impact_count > int'(hold_ticks)) begin
					r.risk = drr_pkg::RISK_CRITICAL;
					r.alert = drr_pkg::ALERT_CRASH;
				end
			end else begin
				impact_on = 1'b0;
				impact_count = 0;
			end
		end

		if (d[65]) begin
			if (d[67:66] >= 2'd2 || perclos > perclos_crit) begin
				r.risk = drr_pkg::RISK_CRITICAL;
				r.alert = drr_pkg::ALERT_DROWSY;
			end else if (perclos > perclos_warn) begin
				r.risk = drr_pkg::RISK_WARNING;
				r.alert = drr_pkg::ALERT_DROWSY;
			end else if (perclos <= perclos_note && d[84]) begin
				r.alert = drr_pkg::ALERT_PHONE;
			end
		end

		if (!d[85]) begin
			r.risk = drr_pkg::RISK_CRITICAL;
			r.alert = drr_pkg::ALERT_SENSOR;
		end

		if (d[0]) begin
			if (mag > harsh_sq) begin
				if (int'(ax) < -HARSH_AX_LIMIT) begin
					if (brake_total < EVENT_MAX)
						brake_total++;
					deduct_points(BRAKE_PENALTY);
				end else if (int'(ax) > HARSH_AX_LIMIT) begin
					if (accel_total < EVENT_MAX)
						accel_total++;
					deduct_points(ACCEL_PENALTY);
				end
			end
			if (yaw_abs > int'(turn_limit)) begin
				if (turn_total < EVENT_MAX)
					turn_total++;
				deduct_points(TURN_PENALTY);
			end
			if (wrap && score < SCORE_CAP)
				score++;
		end

		r.score = 7'(score);
		r.brakes = 16'(brake_total);
		r.accels = 16'(accel_total);
		r.turns = 16'(turn_total);
		expected_reports.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			perclos_crit = drr_pkg::RST_PERCLOS_CRITICAL;
			perclos_warn = drr_pkg::RST_PERCLOS_WARNING;
			perclos_note = drr_pkg::RST_PERCLOS_NOTICE;
			impact_sq = drr_pkg::RST_COLLISION_SQ;
			hold_ticks = drr_pkg::RST_COLLISION_HOLD;
			harsh_sq = drr_pkg::RST_HARSH_SQ;
			turn_limit = drr_pkg::RST_TURN_LIMIT;
			period = drr_pkg::RST_RECOVERY_PERIOD;
			impact_on = 1'b0;
			impact_count = 0;
			phase = 0;
			score = SCORE_CAP;
			brake_total = 0;
			accel_total = 0;
			turn_total = 0;
			errors = 0;
			expected_reports.delete();
			mismatch_count <= 0;
			reports_due <= 0;
		end else begin
			if (cfg_we) begin
				case (drr_pkg::cfg_idx_t'(cfg_index))
				drr_pkg::REG_PERCLOS_CRITICAL: perclos_crit = cfg_data[15:0];
				drr_pkg::REG_PERCLOS_WARNING:  perclos_warn = cfg_data[15:0];
				drr_pkg::REG_PERCLOS_NOTICE:   perclos_note = cfg_data[15:0];
				drr_pkg::REG_COLLISION_SQ:     impact_sq = cfg_data;
				drr_pkg::REG_COLLISION_HOLD:   hold_ticks = cfg_data[15:0];
				drr_pkg::REG_HARSH_SQ:         harsh_sq = cfg_data;
				drr_pkg::REG_TURN_LIMIT:       turn_limit = cfg_data[14:0];
				drr_pkg::REG_RECOVERY_PERIOD:  period = cfg_data[15:0];
				default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got.risk = drr_pkg::risk_t'(m_tdata[1:0]);
				got.alert = drr_pkg::alert_t'(m_tdata[4:2]);
				got.score = m_tdata[11:5];
				got.brakes = m_tdata[27:12];
				got.accels = m_tdata[43:28];
				got.turns = m_tdata[59:44];
				if (expected_reports.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result %h at %0t", m_tdata, $realtime);
				end else begin
					want = expected_reports.pop_front();
					if (got !== want) begin
						errors++;
						if (errors <= 10)
							$display({"mismatch at %0t: risk %0d/%0d alert %0d/%0d ",
								"score %0d/%0d brake %0d/%0d accel %0d/%0d turn %0d/%0d",
								" (expected/actual)"}, $realtime,
								want.risk, got.risk, want.alert, got.alert,
								want.score, got.score, want.brakes, got.brakes,
								want.accels, got.accels, want.turns, got.turns);
					end
				end
			end
			if (s_tvalid && s_tready)
				apply_tick_rules(s_tdata);
			mismatch_count <= errors;
			reports_due <= expected_reports.size();
		end
	end

endmodule

/* sim/driver_risk_rule_engine_test.sv */
// Testbench top for the driver risk rule engine: clock, reset, tick requests,
// register settings and verdict. Depends on drr_pkg, the engine and its checker.
module driver_risk_rule_engine_test;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASE_TICKS = 190;
	localparam int PHASES = 8;

	typedef enum int {
		CFG_DEFAULTS,
		CFG_FLOOR,
		CFG_CEILING,
		CFG_TIGHT,
		CFG_SCATTER
	} cfg_plan_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic [drr_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
	logic                            m_tready = 1'b0;
	logic                            cfg_we = 1'b0;
	logic [drr_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
	logic [drr_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
	wire                             s_tready;
	wire                             m_tvalid;
	wire [drr_pkg::OUT_TDATA_W-1:0]  m_tdata;
	int                              mismatch_count;
	int                              reports_due;

	int send_idle_pct = 0;
	int stall_pct = 0;
	int impact_left = 0;
	int quiet_cycles = 0;

	cfg_plan_t phase_plan[PHASES] = '{CFG_TIGHT, CFG_FLOOR, CFG_TIGHT, CFG_CEILING,
		CFG_DEFAULTS, CFG_TIGHT, CFG_SCATTER, CFG_TIGHT};

	driver_risk_rule_engine i_dut (.*);

	driver_risk_rule_engine_check i_check (.*);

	always #5 clk = ~clk;

	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic logic [15:0] signed_near(int lo, int hi);
		int m;
		m = $urandom_range(hi, lo);
		return 16'($urandom_range(1) ? -m : m);
	endfunction

	task automatic write_register(input drr_pkg::cfg_idx_t idx,
			input logic [drr_pkg::CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(input cfg_plan_t plan);
		logic [drr_pkg::CFG_DATA_W-1:0] vals[8];
		case (plan)
		CFG_DEFAULTS: begin
			vals[drr_pkg::REG_PERCLOS_CRITICAL] = 32'(drr_pkg::RST_PERCLOS_CRITICAL);
			vals[drr_pkg::REG_PERCLOS_WARNING] = 32'(drr_pkg::RST_PERCLOS_WARNING);
			vals[drr_pkg::REG_PERCLOS_NOTICE] = 32'(drr_pkg::RST_PERCLOS_NOTICE);
			vals[drr_pkg::REG_COLLISION_SQ] = drr_pkg::RST_COLLISION_SQ;
			vals[drr_pkg::REG_COLLISION_HOLD] = 32'(drr_pkg::RST_COLLISION_HOLD);
			vals[drr_pkg::REG_HARSH_SQ] = drr_pkg::RST_HARSH_SQ;
			vals[drr_pkg::REG_TURN_LIMIT] = 32'(drr_pkg::RST_TURN_LIMIT);
			vals[drr_pkg::REG_RECOVERY_PERIOD] = 32'(drr_pkg::RST_RECOVERY_PERIOD);
		end
		CFG_FLOOR: begin
			foreach (vals[i])
				vals[i] = '0;
			vals[drr_pkg::REG_RECOVERY_PERIOD] = 32'd1;
		end
		CFG_CEILING: begin
			vals[drr_pkg::REG_PERCLOS_CRITICAL] = 32'h0000_FFFF;
			vals[drr_pkg::REG_PERCLOS_WARNING] = 32'h0000_FFFF;
			vals[drr_pkg::REG_PERCLOS_NOTICE] = 32'h0000_FFFF;
			vals[drr_pkg::REG_COLLISION_SQ] = 32'hFFFF_FFFF;
			vals[drr_pkg::REG_COLLISION_HOLD] = 32'h0000_FFFF;
			vals[drr_pkg::REG_HARSH_SQ] = 32'hFFFF_FFFF;
			vals[drr_pkg::REG_TURN_LIMIT] = 32'h0000_7FFF;
			vals[drr_pkg::REG_RECOVERY_PERIOD] = 32'h0000_FFFF;
		end
		CFG_TIGHT: begin
			vals[drr_pkg::REG_PERCLOS_CRITICAL] = $urandom_range(65535, 40000);
			vals[drr_pkg::REG_PERCLOS_WARNING] = $urandom_range(40000, 20000);
			vals[drr_pkg::REG_PERCLOS_NOTICE] = $urandom_range(20000, 0);
			vals[drr_pkg::REG_COLLISION_SQ] = $urandom_range(2000000, 0);
			vals[drr_pkg::REG_COLLISION_HOLD] = $urandom_range(12, 0);
			vals[drr_pkg::REG_HARSH_SQ] = $urandom_range(20000, 0);
			vals[drr_pkg::REG_TURN_LIMIT] = $urandom_range(4000, 0);
			vals[drr_pkg::REG_RECOVERY_PERIOD] = $urandom_range(12, 1);
		end
		default: begin
			foreach (vals[i])
				vals[i] = $urandom;
			vals[drr_pkg::REG_PERCLOS_CRITICAL][31:16] = '0;
			vals[drr_pkg::REG_PERCLOS_WARNING][31:16] = '0;
			vals[drr_pkg::REG_PERCLOS_NOTICE][31:16] = '0;
			vals[drr_pkg::REG_COLLISION_HOLD][31:16] = '0;
			vals[drr_pkg::REG_TURN_LIMIT][31:15] = '0;
			vals[drr_pkg::REG_RECOVERY_PERIOD] = $urandom_range(65535, 1);
		end
		endcase
		foreach (vals[i])
			write_register(drr_pkg::cfg_idx_t'(i), vals[i]);
	endtask

	// lower the request and let the pipeline empty
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do
			@(negedge clk);
		while (reports_due != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic send_tick(input logic imu, input logic [15:0] ax, ay, az, gz,
			input logic cam, input logic [1:0] lvl, input logic [15:0] perclos,
			input logic phone, input logic ok);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {2'b0, ok, phone, perclos, lvl, cam, gz, az, ay, ax, imu};
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
	endtask

	task automatic send_random_tick();
		logic [15:0] ax, ay, az, gz, perclos;
		logic [1:0] lvl;
		// sustained impact runs drive the collision hold timer
		if (impact_left == 0 && $urandom_range(24) == 0)
			impact_left = $urandom_range(40, 1);
		if (impact_left != 0) begin
			impact_left--;
			ax = signed_near(1500, 32767);
			ay = signed_near(0, 2000);
			az = signed_near(0, 2000);
		end else begin
			case ($urandom_range(3))
			0: begin
				ax = signed_near(0, 60);
				ay = signed_near(0, 40);
				az = signed_near(0, 40);
			end
			1: begin
				ax = signed_near(44, 52);
				ay = signed_near(0, 90);
				az = signed_near(0, 20);
			end
			2: begin
				ax = 16'($urandom);
				ay = 16'($urandom);
				az = 16'($urandom);
			end
			default: begin
				ax = signed_near(1000, 1500);
				ay = signed_near(0, 500);
				az = signed_near(0, 500);
			end
			endcase
		end
		case ($urandom_range(3))
		0: gz = signed_near(1800, 2050);
		1: gz = 16'($urandom);
		2: gz = signed_near(0, 500);
		default: gz = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
		endcase
		lvl = ($urandom_range(4) == 0) ? 2'($urandom_range(3, 2)) : 2'($urandom_range(1, 0));
		case ($urandom_range(2))
		0: perclos = 16'($urandom);
		1: perclos = 16'($urandom_range(12000, 0));
		default: begin
			case ($urandom_range(2))
			0: perclos = drr_pkg::RST_PERCLOS_NOTICE;
			1: perclos = drr_pkg::RST_PERCLOS_WARNING;
			default: perclos = drr_pkg::RST_PERCLOS_CRITICAL;
			endcase
			perclos = perclos + 16'($urandom_range(4, 0)) - 16'd2;
		end
		endcase
		send_tick($urandom_range(9) != 0, ax, ay, az, gz, $urandom_range(7) != 0, lvl,
			perclos, 1'($urandom_range(1)), $urandom_range(15) != 0);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// edge cases at reset thresholds
		send_tick(1, 0, 0, 0, 0, 1, 0, 0, 0, 1);
		send_tick(1, 32767, 32767, 32767, 32767, 1, 3, 65535, 1, 1);
		send_tick(1, -32768, -32768, -32768, -32768, 1, 0, 0, 1, 1);
		send_tick(1, -49, 60, 0, 0, 0, 0, 0, 0, 1);
		send_tick(1, -48, 60, 0, 0, 0, 0, 0, 0, 1);
		send_tick(1, 48, 60, 0, 0, 0, 0, 0, 0, 1);
		send_tick(1, 49, 60, 0, 0, 0, 0, 0, 0, 1);
		send_tick(1, 49, 0, 0, 0, 0, 0, 0, 0, 1);
		send_tick(1, 0, 0, 0, 1920, 0, 0, 0, 0, 1);
		send_tick(1, 0, 0, 0, -1921, 0, 0, 0, 0, 1);
		send_tick(0, -32768, 0, 0, 32767, 1, 0, 0, 1, 1);
		send_tick(1, 0, 0, 0, 0, 1, 1, 32768, 0, 1);
		send_tick(1, 0, 0, 0, 0, 1, 1, 32769, 0, 1);
		send_tick(1, 0, 0, 0, 0, 1, 0, 19661, 1, 1);
		send_tick(1, 0, 0, 0, 0, 1, 0, 19662, 0, 1);
		send_tick(1, 0, 0, 0, 0, 1, 0, 9830, 1, 1);
		send_tick(1, 0, 0, 0, 0, 1, 0, 9831, 1, 1);
		send_tick(1, 0, 0, 0, 0, 1, 2, 0, 0, 1);
		send_tick(1, 0, 0, 0, 0, 1, 1, 0, 0, 1);
		send_tick(1, 0, 0, 0, 0, 0, 3, 65535, 1, 1);
		send_tick(1, 0, 0, 0, 0, 1, 0, 0, 0, 0);
		send_tick(1, 32767, 0, 0, 0, 1, 3, 65535, 1, 0);

		for (int p = 0; p < PHASES; p++) begin
			wait_drained();
			set_config(phase_plan[p]);
			case (p % 4)
			0: begin send_idle_pct = 0;  stall_pct = 0;  end
			1: begin send_idle_pct = 84; stall_pct = 0;  end
			2: begin send_idle_pct = 0;  stall_pct = 84; end
			default: begin send_idle_pct = 35; stall_pct = 35; end
			endcase
			@(negedge clk);
			repeat (PHASE_TICKS) send_random_tick();
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && reports_due == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
